// ===== design/mrbpm_pkg.sv =====
// mrbpm_pkg: shared constants, codes and types for the mono ring buffer pan mixer
// no dependencies; imported by the core, the mixer and the checker
package mrbpm_pkg;

  localparam int unsigned DEPTH      = 8192;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = ADDR_W + 1;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned VOLUME_W   = 16;
  localparam int unsigned PAN_W      = 17;
  localparam int unsigned GAIN_W     = 18;
  localparam int unsigned OUT_W      = 18;
  localparam int unsigned LEVEL_W    = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [VOLUME_W-1:0]  VOLUME_RESET = 16'd32768;
  localparam logic signed [18:0]   Q_ONE_S      = 19'sd32768;
  localparam logic signed [19:0]   OUT_MAX_S    = 20'sd65536;
  localparam logic signed [19:0]   OUT_MIN_S    = -20'sd65536;
  localparam logic [CNT_W-1:0]     FULL_LEVEL   = CNT_W'(DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLUME  = 2'd0,
    CFG_PAN     = 2'd1,
    CFG_PLAYING = 2'd2,
    CFG_PAUSED  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [VOLUME_W-1:0]     volume;
    logic signed [PAN_W-1:0] pan;
  } mix_cfg_t;

endpackage

// ===== design/mono_ring_buffer_pan_mixer_core.sv =====
// mono_ring_buffer_pan_mixer_core: sample fifo in ram with volume and pan stereo mixer
// depends on mrbpm_pkg, mrbpm_ram, mrbpm_mix
// writes and silent or underrun renders give their result in the cycle after transfer;
//   renders that consume a sample pass the ram read register, then are scaled and registered in ST_MIX
// input is stalled while in ST_MIX, so a consuming render blocks new input until its frame is registered
// reset: counts cleared, volume unity, pan centered, not playing, not paused; ram undefined
module mono_ring_buffer_pan_mixer_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  cmd_i,
  input  logic signed [mrbpm_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  kind_o,
  output logic                                  accepted_o,
  output logic signed [mrbpm_pkg::OUT_W-1:0]    left_o,
  output logic signed [mrbpm_pkg::OUT_W-1:0]    right_o,
  output logic                                  underrun_o,
  output logic [mrbpm_pkg::LEVEL_W-1:0]         level_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mrbpm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mrbpm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import mrbpm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_MIX
  } state_e;

  state_e state_q;

  mix_cfg_t         cfg_q;
  logic             playing_q;
  logic             paused_q;
  logic [CNT_W-1:0] wr_cnt_q, wr_cnt_d;
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic [CNT_W-1:0] level_q, level_d;

  logic                     out_valid_q;
  logic                     kind_q;
  logic                     accepted_q;
  logic signed [OUT_W-1:0]  left_q;
  logic signed [OUT_W-1:0]  right_q;
  logic                     underrun_q;
  logic [LEVEL_W-1:0]       level_out_q;

  logic                     in_xfer;
  logic                     out_free;
  logic                     active;
  logic                     is_render;
  logic                     wr_en;
  logic                     consume;
  logic [SAMPLE_W-1:0]      ram_rdata;
  logic signed [OUT_W-1:0]  mix_left;
  logic signed [OUT_W-1:0]  mix_right;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q == ST_MIX) || !out_free;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign active      = playing_q && !paused_q;
  assign is_render   = (cmd_i == CMD_RENDER);
  assign level_q     = wr_cnt_q - rd_cnt_q;
  assign wr_en       = in_xfer && !is_render && (level_q < FULL_LEVEL);
  assign consume     = in_xfer && is_render && active && (level_q != '0);
  assign wr_cnt_d    = wr_cnt_q + CNT_W'(wr_en);
  assign rd_cnt_d    = rd_cnt_q + CNT_W'(consume);
  assign level_d     = wr_cnt_d - rd_cnt_d;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volume <= VOLUME_RESET;
      cfg_q.pan    <= '0;
      playing_q    <= 1'b0;
      paused_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_VOLUME:  cfg_q.volume <= cfg_data_i[VOLUME_W-1:0];
        CFG_PAN:     cfg_q.pan    <= cfg_data_i[PAN_W-1:0];
        CFG_PLAYING: playing_q    <= cfg_data_i[0];
        CFG_PAUSED:  paused_q     <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q <= '0;
      rd_cnt_q <= '0;
    end else begin
      wr_cnt_q <= wr_cnt_d;
      rd_cnt_q <= rd_cnt_d;
    end
  end

  mrbpm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_cnt_q[ADDR_W-1:0]),
    .wdata_i (sample_i),
    .re_i    (consume),
    .raddr_i (rd_cnt_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  mrbpm_mix u_mix (
    .clk_i    (clk_i),
    .start_i  (consume),
    .cfg_i    (cfg_q),
    .sample_i (ram_rdata),
    .left_o   (mix_left),
    .right_o  (mix_right)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      kind_q      <= 1'b0;
      accepted_q  <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      underrun_q  <= 1'b0;
      level_out_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (consume) begin
            state_q     <= ST_MIX;
            out_valid_q <= 1'b0;
          end else if (in_xfer) begin
            out_valid_q <= 1'b1;
            kind_q      <= cmd_i;
            accepted_q  <= wr_en;
            left_q      <= '0;
            right_q     <= '0;
            underrun_q  <= is_render && active;
            level_out_q <= LEVEL_W'(level_d);
          end else if (!out_stall_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_MIX: begin
          if (out_free) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            kind_q      <= CMD_RENDER;
            accepted_q  <= 1'b0;
            left_q      <= mix_left;
            right_q     <= mix_right;
            underrun_q  <= 1'b0;
            level_out_q <= LEVEL_W'(level_q);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign accepted_o  = accepted_q;
  assign left_o      = left_q;
  assign right_o     = right_q;
  assign underrun_o  = underrun_q;
  assign level_o     = level_out_q;

endmodule

// ===== design/mrbpm_ram.sv =====
// mrbpm_ram: generic single write port, single read port ram with registered read
// no dependencies
module mrbpm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mrbpm_mix.sv =====
// mrbpm_mix: volume and pan gain stage followed by the sample scaling stage
// depends on mrbpm_pkg
module mrbpm_mix (
  input  logic                               clk_i,
  input  logic                               start_i,
  input  mrbpm_pkg::mix_cfg_t                cfg_i,
  input  logic signed [mrbpm_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [mrbpm_pkg::OUT_W-1:0]    left_o,
  output logic signed [mrbpm_pkg::OUT_W-1:0]    right_o
);

  import mrbpm_pkg::*;

  logic [GAIN_W-1:0] gl_d, gl_q;
  logic [GAIN_W-1:0] gr_d, gr_q;
  logic signed [18:0] pan_x;

  function automatic logic [GAIN_W-1:0] gain(input logic [VOLUME_W-1:0] vol,
                                             input logic signed [18:0] pp);
    logic [32:0] prod;
    begin
      prod = {17'b0, vol} * {16'b0, pp[16:0]};
      if (pp < 0) begin
        gain = '0;
      end else begin
        gain = prod[32:15];
      end
    end
  endfunction

  function automatic logic signed [OUT_W-1:0] scale(input logic signed [SAMPLE_W-1:0] s,
                                                    input logic [GAIN_W-1:0] g);
    logic signed [34:0] se;
    logic signed [34:0] ge;
    logic signed [34:0] prod;
    logic signed [19:0] sh;
    begin
      se   = {{19{s[15]}}, s};
      ge   = {17'b0, g};
      prod = se * ge;
      sh   = prod[34:15];
      if (sh > OUT_MAX_S) begin
        scale = OUT_MAX_S[OUT_W-1:0];
      end else if (sh < OUT_MIN_S) begin
        scale = OUT_MIN_S[OUT_W-1:0];
      end else begin
        scale = sh[OUT_W-1:0];
      end
    end
  endfunction

  assign pan_x = {{2{cfg_i.pan[PAN_W-1]}}, cfg_i.pan};

  always_comb begin
    gl_d = gain(cfg_i.volume, Q_ONE_S - pan_x);
    gr_d = gain(cfg_i.volume, Q_ONE_S + pan_x);
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      gl_q <= gl_d;
      gr_q <= gr_d;
    end
  end

  assign left_o  = scale(sample_i, gl_q);
  assign right_o = scale(sample_i, gr_q);

endmodule

// ===== design/mrbpm_checker.sv =====
// mrbpm_checker: port level assertions for the mono ring buffer pan mixer
// depends on mrbpm_pkg; bound to mono_ring_buffer_pan_mixer_core
module mrbpm_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic                                  kind_o,
  input logic                                  accepted_o,
  input logic signed [mrbpm_pkg::OUT_W-1:0]    left_o,
  input logic signed [mrbpm_pkg::OUT_W-1:0]    right_o,
  input logic                                  underrun_o,
  input logic [mrbpm_pkg::LEVEL_W-1:0]         level_o
);

  import mrbpm_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_o) && $stable(right_o)
      && $stable(level_o) && $stable(kind_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == CMD_WRITE) |-> (left_o == '0) && (right_o == '0) && !underrun_o)
    else $error("write acknowledge carries frame data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == CMD_RENDER) |-> !accepted_o
      && (!underrun_o || ((left_o == '0) && (right_o == '0) && (level_o == '0))))
    else $error("render result inconsistent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(level_o) <= DEPTH))
    else $error("level above buffer depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result stalled");

endmodule

bind mono_ring_buffer_pan_mixer_core mrbpm_checker u_mrbpm_checker (.*);
